FILE: rtl/tpsg_pkg.sv
package tpsg_pkg;

  // Field widths
  localparam int STEP_W  = 9;
  localparam int AMP_W   = 16;
  localparam int OUT_W   = 17;
  localparam int SIN_W   = 18;
  localparam int LIMIT_W = 20;
  localparam int COUNT_W = 21;
  localparam int IN_W    = 64;
  localparam int RES_W   = 104;

  // Defaults for the top-level parameters
  localparam int TABLE_POINTS_DEF = 500;
  localparam int MOD_OFFSET_DEF   = 9;

  // Q30 polynomial constants for sin(pi/2 * t)
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint SIN_C0  = 64'sd1686629713;
  localparam longint SIN_C1  = -64'sd693598668;
  localparam longint SIN_C2  = 64'sd85569306;
  localparam longint SIN_C3  = -64'sd5026993;
  localparam longint SIN_C4  = 64'sd172273;
  localparam longint ROUND_Q16 = 64'sd8192;
  localparam longint SCALE_Q16 = 64'sd16384;
  localparam longint MAG_MAX   = 64'sd65536;
  localparam longint MOD_GAIN  = 64'sd65535;

  // Per-beat drive data carried alongside the phase indices
  typedef struct packed {
    logic [AMP_W-1:0] amp_a;
    logic [AMP_W-1:0] amp_b;
    logic [AMP_W-1:0] amp_c;
    logic             inv;
  } tpsg_drive_t;

  // Sine in Q1.16 from a 32-bit phase word (elaboration only)
  function automatic logic signed [SIN_W-1:0] sine_from_phase(longint p);
    logic [1:0] q;
    longint     t;
    longint     t2;
    longint     r;
    longint     s;
    longint     mag;
    q = 2'((p >>> 30) & 64'sd3);
    t = p & 64'sh3FFF_FFFF;
    if (q[0]) begin
      t = Q30_ONE - t;
    end
    t2 = (t * t) / Q30_ONE;
    r  = SIN_C4;
    r  = SIN_C3 + (r * t2) / Q30_ONE;
    r  = SIN_C2 + (r * t2) / Q30_ONE;
    r  = SIN_C1 + (r * t2) / Q30_ONE;
    r  = SIN_C0 + (r * t2) / Q30_ONE;
    s  = (r * t) / Q30_ONE;
    if (s < 0) begin
      s = 0;
    end
    mag = (s + ROUND_Q16) / SCALE_Q16;
    if (mag > MAG_MAX) begin
      mag = MAG_MAX;
    end
    return q[1] ? -SIN_W'(mag) : SIN_W'(mag);
  endfunction

  // Modulation word: sign(S) * ((|S| * 65535) >> 16)
  function automatic logic signed [SIN_W-1:0] mod_from_sine(logic signed [SIN_W-1:0] s);
    longint mag;
    longint v;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    v   = (mag * MOD_GAIN) >>> 16;
    return (s < 0) ? -SIN_W'(v) : SIN_W'(v);
  endfunction

endpackage

FILE: rtl/tpsg_phase.sv
module tpsg_phase #(
  parameter int TABLE_POINTS = tpsg_pkg::TABLE_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              req,
  input  logic [$clog2(TABLE_POINTS)-1:0]   step_mod,
  input  logic [tpsg_pkg::LIMIT_W-1:0]      tick_limit,
  output logic [$clog2(TABLE_POINTS)-1:0]   idx_a,
  output logic [$clog2(TABLE_POINTS)-1:0]   idx_b,
  output logic [$clog2(TABLE_POINTS)-1:0]   idx_c
);
  import tpsg_pkg::*;

  localparam int IW = $clog2(TABLE_POINTS);
  localparam logic [IW-1:0] LAST    = IW'(TABLE_POINTS - 1);
  localparam logic [IW-1:0] B_START = IW'((((2 * TABLE_POINTS) + 1) / 3) % TABLE_POINTS);
  localparam logic [IW-1:0] C_START = IW'(((TABLE_POINTS + 1) / 3) % TABLE_POINTS);
  localparam logic [IW:0]   N_EXT   = (IW+1)'(TABLE_POINTS);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [IW-1:0]      a_r, b_r, c_r;
  logic [IW-1:0]      a_nxt, b_nxt, c_nxt;
  logic               prev_r;
  logic               wrap;
  logic [IW-1:0]      a_adv, b_adv, c_adv;

  function automatic logic [IW-1:0] step_one(logic [IW-1:0] v);
    return (v == LAST) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] add_mod(logic [IW-1:0] v, logic [IW-1:0] s);
    logic [IW:0] sum;
    sum = {1'b0, v} + {1'b0, s};
    if (sum >= N_EXT) begin
      sum = sum - N_EXT;
    end
    return sum[IW-1:0];
  endfunction

  // Advance on count overrun, then take a jump on a request edge at phase A zero
  always_comb begin
    wrap  = count_r > {1'b0, tick_limit};
    a_adv = wrap ? step_one(a_r) : a_r;
    b_adv = wrap ? step_one(b_r) : b_r;
    c_adv = wrap ? step_one(c_r) : c_r;
    a_nxt = a_adv;
    b_nxt = b_adv;
    c_nxt = c_adv;
    // armed and taken in the same beat, so no armed flag is kept
    if (req && !prev_r && (a_adv == '0)) begin
      a_nxt = add_mod(a_adv, step_mod);
      b_nxt = add_mod(b_adv, step_mod);
      c_nxt = add_mod(c_adv, step_mod);
    end
    count_nxt = (wrap ? '0 : count_r) + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      a_r     <= '0;
      b_r     <= B_START;
      c_r     <= C_START;
      prev_r  <= 1'b0;
    end else if (adv) begin
      count_r <= count_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      prev_r  <= req;
    end
  end

  assign idx_a = a_r;
  assign idx_b = b_r;
  assign idx_c = c_r;

endmodule

FILE: rtl/tpsg_rom.sv
module tpsg_rom #(
  parameter int TABLE_POINTS = tpsg_pkg::TABLE_POINTS_DEF,
  parameter int MOD_OFFSET   = tpsg_pkg::MOD_OFFSET_DEF,
  parameter bit MOD_WORDS    = 1'b0
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [$clog2(TABLE_POINTS)-1:0]        addr,
  output logic signed [tpsg_pkg::SIN_W-1:0]      data
);
  import tpsg_pkg::*;

  logic signed [SIN_W-1:0] rom [TABLE_POINTS];
  logic signed [SIN_W-1:0] data_r;

  // Build the table at elaboration; modulation words are pre-shifted by the offset
  for (genvar i = 0; i < TABLE_POINTS; i++) begin : g_rom
    localparam int     J = MOD_WORDS ? ((i + MOD_OFFSET) % TABLE_POINTS) : i;
    localparam longint P = (longint'(J) << 32) / TABLE_POINTS;
    localparam logic signed [SIN_W-1:0] S = sine_from_phase(P);
    localparam logic signed [SIN_W-1:0] V = MOD_WORDS ? mod_from_sine(S) : S;
    assign rom[i] = V;
  end

  // Registered read, held while the stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom[addr];
    end
  end

  assign data = data_r;

endmodule

FILE: rtl/tpsg_scale.sv
module tpsg_scale (
  input  logic [tpsg_pkg::AMP_W-1:0]         amp,
  input  logic signed [tpsg_pkg::SIN_W-1:0]  sine,
  output logic signed [tpsg_pkg::OUT_W-1:0]  volt
);
  import tpsg_pkg::*;

  localparam int PROD_W = AMP_W + SIN_W - 1;

  logic [SIN_W-2:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [OUT_W-1:0]  scaled;

  // Scale magnitude, round at bit 16, restore the sign
  always_comb begin
    mag     = sine[SIN_W-1] ? (SIN_W-1)'(-sine) : sine[SIN_W-2:0];
    prod    = PROD_W'(amp) * PROD_W'(mag);
    rounded = prod + PROD_W'(32768);
    scaled  = rounded[16 +: OUT_W];
    volt    = sine[SIN_W-1] ? -signed'(scaled) : signed'(scaled);
  end

endmodule

FILE: rtl/three_phase_sine_generator_core.sv
// Channel  Dir  Ports                          Bits
// in       in   in_tvalid/in_tready/in_tdata   64  (one tick per beat)
// out      out  out_tvalid/out_tready/out_tdata 104 (one result per tick)
// cfg      in   cfg_valid/cfg_ready/cfg_data   20  (tick_limit, always ready)
//
// One beat in and one beat out per cycle while out_tready holds high, through
// input register, phase index state, table read register, result register.
// Each stage holds only while the one after it is full and stalled, so a
// new beat is taken whenever any stage ahead has room.
// rst_n is synchronous; indices return to 0, (2N+1)/3 and (N+1)/3.
module three_phase_sine_generator_core #(
  parameter int TABLE_POINTS = tpsg_pkg::TABLE_POINTS_DEF,
  parameter int MOD_OFFSET   = tpsg_pkg::MOD_OFFSET_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // step_request[0], step_size[9:1], amplitude_a[25:10], amplitude_b[41:26],
  // amplitude_c[57:42], inverse_sequence[58], zero[63:59]
  input  logic [tpsg_pkg::IN_W-1:0]     in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // voltage_a[16:0], voltage_b[33:17], voltage_c[50:34], modulation_a[67:51],
  // modulation_b[84:68], modulation_c[101:85], zero[103:102]
  output logic [tpsg_pkg::RES_W-1:0]    out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [tpsg_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);
  import tpsg_pkg::*;

  localparam int IW          = $clog2(TABLE_POINTS);
  localparam int STEP_FOLDS  = ((2 ** STEP_W) - 1) / TABLE_POINTS;

  // Stage enables
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  // Configuration
  logic [LIMIT_W-1:0] limit_r;

  // Stage 1: input register
  logic [STEP_W-1:0] step_red;
  logic              req1_r;
  logic [IW-1:0]     step1_r;
  tpsg_drive_t       drv1_r, drv2_r, drv3_r;

  // Stage 2: phase state
  logic [IW-1:0] idx_a, idx_b, idx_c;

  // Stage 3: table reads
  logic signed [SIN_W-1:0] sin_a, sin_b, sin_c;
  logic signed [SIN_W-1:0] mod_a, mod_b, mod_c;
  logic signed [OUT_W-1:0] volt_a, volt_b, volt_c;

  // Stage 4: result register
  logic [RES_W-1:0] res_r, res_nxt;

  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // Hold the tick limit
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // Fold the step size into one table period
  always_comb begin
    step_red = in_tdata[9:1];
    for (int m = 1; m <= STEP_FOLDS; m++) begin
      if (in_tdata[9:1] >= STEP_W'(m * TABLE_POINTS)) begin
        step_red = in_tdata[9:1] - STEP_W'(m * TABLE_POINTS);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      req1_r       <= in_tdata[0];
      step1_r      <= IW'(step_red);
      drv1_r.amp_a <= in_tdata[25:10];
      drv1_r.amp_b <= in_tdata[41:26];
      drv1_r.amp_c <= in_tdata[57:42];
      drv1_r.inv   <= in_tdata[58];
    end
    if (en2) drv2_r <= drv1_r;
    if (en3) drv3_r <= drv2_r;
    if (en4) res_r  <= res_nxt;
  end

  // Update phase indices as a beat leaves the input register
  tpsg_phase #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (v1_r && en2),
    .req        (req1_r),
    .step_mod   (step1_r),
    .tick_limit (limit_r),
    .idx_a      (idx_a),
    .idx_b      (idx_b),
    .idx_c      (idx_c)
  );

  // Sine and modulation tables, one read port each
  tpsg_rom #(.TABLE_POINTS(TABLE_POINTS), .MOD_OFFSET(MOD_OFFSET), .MOD_WORDS(1'b0))
    u_sin_a (.clk(clk), .en(en3), .addr(idx_a), .data(sin_a));
  tpsg_rom #(.TABLE_POINTS(TABLE_POINTS), .MOD_OFFSET(MOD_OFFSET), .MOD_WORDS(1'b0))
    u_sin_b (.clk(clk), .en(en3), .addr(idx_b), .data(sin_b));
  tpsg_rom #(.TABLE_POINTS(TABLE_POINTS), .MOD_OFFSET(MOD_OFFSET), .MOD_WORDS(1'b0))
    u_sin_c (.clk(clk), .en(en3), .addr(idx_c), .data(sin_c));
  tpsg_rom #(.TABLE_POINTS(TABLE_POINTS), .MOD_OFFSET(MOD_OFFSET), .MOD_WORDS(1'b1))
    u_mod_a (.clk(clk), .en(en3), .addr(idx_a), .data(mod_a));
  tpsg_rom #(.TABLE_POINTS(TABLE_POINTS), .MOD_OFFSET(MOD_OFFSET), .MOD_WORDS(1'b1))
    u_mod_b (.clk(clk), .en(en3), .addr(idx_b), .data(mod_b));
  tpsg_rom #(.TABLE_POINTS(TABLE_POINTS), .MOD_OFFSET(MOD_OFFSET), .MOD_WORDS(1'b1))
    u_mod_c (.clk(clk), .en(en3), .addr(idx_c), .data(mod_c));

  // Amplitude scaling per phase
  tpsg_scale u_scale_a (.amp(drv3_r.amp_a), .sine(sin_a), .volt(volt_a));
  tpsg_scale u_scale_b (.amp(drv3_r.amp_b), .sine(sin_b), .volt(volt_b));
  tpsg_scale u_scale_c (.amp(drv3_r.amp_c), .sine(sin_c), .volt(volt_c));

  // Pack the result, swapping B and C under inverse sequence
  always_comb begin
    res_nxt          = '0;
    res_nxt[16:0]    = volt_a;
    res_nxt[33:17]   = drv3_r.inv ? volt_c : volt_b;
    res_nxt[50:34]   = drv3_r.inv ? volt_b : volt_c;
    res_nxt[67:51]   = mod_a[OUT_W-1:0];
    res_nxt[84:68]   = mod_b[OUT_W-1:0];
    res_nxt[101:85]  = mod_c[OUT_W-1:0];
  end

  assign out_tdata  = res_r;
  assign out_tvalid = v4_r;

endmodule
